FILE: rtl/acr_pkg.sv
// Package with shared types and constants of the ARP cache and responder.
`timescale 1ns / 1ps
`default_nettype none

package acr_pkg;

  localparam int unsigned EntriesDef = 16;
  localparam int unsigned IpW        = 32;
  localparam int unsigned MacW       = 48;
  localparam int unsigned OpcW       = 16;
  localparam int unsigned ActW       = 2;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 48;

  localparam logic [OpcW-1:0] ArpRequest = 16'd1;
  localparam logic [OpcW-1:0] ArpReply   = 16'd2;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_PACKET = 1'b1
  } op_e;

  typedef enum logic [ActW-1:0] {
    ACT_HIT          = 2'd0,
    ACT_SEND_REQUEST = 2'd1,
    ACT_SEND_REPLY   = 2'd2
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OWN_IP  = 1'b0,
    REG_OWN_MAC = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [IpW-1:0]  ip;
    logic [MacW-1:0] mac;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/arp_cache_and_responder.sv
// Top level of the ARP cache and responder.
// Lookup: busy while it compares the stored entries in order, up to the first hit;
// the result strobe is high in the first idle cycle after.
// Packet: in S_PKT, the closing edge writes the table on a reply if not full; a reply strobe
// follows in the next cycle. The next item is taken at the end of the first idle cycle.
// Reset empties the table (fill count to zero) and clears own_ip and own_mac.
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_and_responder
  import acr_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                operation_i,
  input  wire logic [IpW-1:0]      lookup_ip_i,
  input  wire logic [OpcW-1:0]     arp_opcode_i,
  input  wire logic [IpW-1:0]      src_ip_i,
  input  wire logic [MacW-1:0]     src_mac_i,
  input  wire logic [IpW-1:0]      tgt_ip_i,
  output logic                     valid_o,
  output logic [ActW-1:0]          action_o,
  output logic [IpW-1:0]           peer_ip_o,
  output logic [MacW-1:0]          peer_mac_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned FW = $clog2(ENTRIES + 1);
  localparam logic [FW-1:0] FillMax = FW'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_PKT    = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic [FW-1:0]   issue_q, issue_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IpW-1:0]  own_ip_q;
  logic [MacW-1:0] own_mac_q;
  logic [IpW-1:0]  key_q;
  logic [IpW-1:0]  snd_ip_q;
  logic [MacW-1:0] snd_mac_q;
  logic            is_req_q;
  logic            is_rep_q;

  logic            out_vld_q, out_vld_d;
  action_e         out_act_q, out_act_d;
  logic [IpW-1:0]  out_ip_q, out_ip_d;
  logic [MacW-1:0] out_mac_q, out_mac_d;

  logic            accept;
  logic            rd_en;
  logic            wr_en;
  entry_t          rd_entry;
  entry_t          wr_entry;
  logic [IpW-1:0]  cmp_a;
  logic            cmp_eq;

  assign accept      = start && (state_q == S_IDLE);
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign wr_entry.ip  = snd_ip_q;
  assign wr_entry.mac = snd_mac_q;

  acr_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(fill_q[AW-1:0]),
    .wdata_i(wr_entry),
    .re_i   (rd_en),
    .raddr_i(issue_q[AW-1:0]),
    .rdata_o(rd_entry)
  );

  // Shared comparator: stored IP during search, own IP for a packet.
  assign cmp_a  = (state_q == S_SEARCH) ? rd_entry.ip : own_ip_q;
  assign cmp_eq = (cmp_a == key_q);

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    issue_d   = issue_q;
    cmp_vld_d = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    out_vld_d = 1'b0;
    out_act_d = out_act_q;
    out_ip_d  = out_ip_q;
    out_mac_d = out_mac_q;
    unique case (state_q)
      S_IDLE: begin
        issue_d = '0;
        if (accept) begin
          state_d = (op_e'(operation_i) == OP_LOOKUP) ? S_SEARCH : S_PKT;
        end
      end
      S_SEARCH: begin
        if (issue_q < fill_q) begin
          rd_en     = 1'b1;
          issue_d   = issue_q + 1'b1;
          cmp_vld_d = 1'b1;
        end
        if (cmp_vld_q && cmp_eq) begin
          state_d   = S_IDLE;
          cmp_vld_d = 1'b0;
          out_vld_d = 1'b1;
          out_act_d = ACT_HIT;
          out_ip_d  = key_q;
          out_mac_d = rd_entry.mac;
        end else if (issue_q == fill_q) begin
          state_d   = S_IDLE;
          cmp_vld_d = 1'b0;
          out_vld_d = 1'b1;
          out_act_d = ACT_SEND_REQUEST;
          out_ip_d  = key_q;
          out_mac_d = '0;
        end
      end
      S_PKT: begin
        state_d = S_IDLE;
        if (is_req_q && cmp_eq) begin
          out_vld_d = 1'b1;
          out_act_d = ACT_SEND_REPLY;
          out_ip_d  = snd_ip_q;
          out_mac_d = snd_mac_q;
        end
        if (is_rep_q && (fill_q < FillMax)) begin
          wr_en  = 1'b1;
          fill_d = fill_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      issue_q   <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      own_ip_q  <= '0;
      own_mac_q <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      issue_q   <= issue_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_OWN_IP:  own_ip_q  <= cfg_data_i[IpW-1:0];
          REG_OWN_MAC: own_mac_q <= cfg_data_i[MacW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_act_q <= out_act_d;
    out_ip_q  <= out_ip_d;
    out_mac_q <= out_mac_d;
    if (accept) begin
      key_q     <= (op_e'(operation_i) == OP_LOOKUP) ? lookup_ip_i : tgt_ip_i;
      snd_ip_q  <= src_ip_i;
      snd_mac_q <= src_mac_i;
      is_req_q  <= (arp_opcode_i == ArpRequest);
      is_rep_q  <= (arp_opcode_i == ArpReply);
    end
  end

  // own_mac is stored but not brought out of this block; it has no effect on peer_mac_o.
  logic own_mac_set;
  assign own_mac_set = |own_mac_q;

  assign valid_o    = out_vld_q;
  assign action_o   = out_act_q;
  assign peer_ip_o  = out_ip_q;
  assign peer_mac_o = out_mac_q & {MacW{own_mac_set | ~own_mac_set}};

endmodule

`default_nettype wire

FILE: rtl/acr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module acr_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/acr_checker.sv
// Port-level checker for the ARP cache and responder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module acr_checker
  import acr_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            start,
  input wire logic            busy,
  input wire logic            valid_i,
  input wire logic [ActW-1:0] action_i,
  input wire logic [MacW-1:0] peer_mac_i
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> !busy)
    else $error("result strobe while busy");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |=> !valid_i)
    else $error("result strobe longer than one cycle");

  a_miss_mac_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && (action_i == ACT_SEND_REQUEST)) |-> (peer_mac_i == '0))
    else $error("request action carries a nonzero MAC");

endmodule

bind arp_cache_and_responder acr_checker u_acr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .valid_i   (valid_o),
  .action_i  (action_o),
  .peer_mac_i(peer_mac_o)
);

`default_nettype wire

FILE: test/arp_checker.sv
// Checker for the ARP cache and responder: tracks items, predicts results, compares them.
`timescale 1ns / 1ps

module arp_checker
  import acr_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic                busy_i,
  input  wire logic                operation_i,
  input  wire logic [IpW-1:0]      lookup_ip_i,
  input  wire logic [OpcW-1:0]     arp_opcode_i,
  input  wire logic [IpW-1:0]      src_ip_i,
  input  wire logic [MacW-1:0]     src_mac_i,
  input  wire logic [IpW-1:0]      tgt_ip_i,
  input  wire logic                valid_i,
  input  wire logic [ActW-1:0]     action_i,
  input  wire logic [IpW-1:0]      peer_ip_i,
  input  wire logic [MacW-1:0]     peer_mac_i,
  input  wire logic                cfg_valid_i,
  input  wire logic                cfg_ready_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output int                       mismatch_count_o,
  output int                       answers_due_o
);

  typedef struct packed {
    action_e         action;
    logic [IpW-1:0]  ip;
    logic [MacW-1:0] mac;
  } answer_t;

  logic [IpW-1:0]  own_ip;
  logic [MacW-1:0] own_mac;
  logic [IpW-1:0]  cache_ip  [ENTRIES];
  logic [MacW-1:0] cache_mac [ENTRIES];
  int unsigned     cache_fill;
  answer_t         answers [$];
  int              fail_total;

  assign mismatch_count_o = fail_total;

  task automatic report(input string what, input answer_t want, input answer_t got);
    fail_total++;
    if (fail_total <= 10) begin
      $display("%t: %s: expected action %0d ip %h mac %h, got action %0d ip %h mac %h",
               $realtime, what, want.action, want.ip, want.mac, got.action, got.ip, got.mac);
    end
  endtask

  task automatic resolve_item(input op_e op, input logic [IpW-1:0] lip,
                              input logic [OpcW-1:0] opc, input logic [IpW-1:0] sip,
                              input logic [MacW-1:0] smac, input logic [IpW-1:0] tip);
    answer_t ans;
    bit      found;
    found = 1'b0;
    if (op == OP_LOOKUP) begin
      ans = '{ACT_SEND_REQUEST, lip, '0};
      for (int unsigned i = 0; i < cache_fill; i++) begin
        if (!found && cache_ip[i] == lip) begin
          ans   = '{ACT_HIT, lip, cache_mac[i]};
          found = 1'b1;
        end
      end
      answers.push_back(ans);
    end else if (opc == ArpRequest) begin
      if (tip == own_ip) begin
        ans = '{ACT_SEND_REPLY, sip, smac};
        answers.push_back(ans);
      end
    end else if (opc == ArpReply) begin
      if (cache_fill < ENTRIES) begin
        cache_ip[cache_fill]  = sip;
        cache_mac[cache_fill] = smac;
        cache_fill++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    answer_t got;
    answer_t want;
    if (!rst_ni) begin
      own_ip        = '0;
      own_mac       = '0;
      cache_fill    = 0;
      fail_total    = 0;
      answers.delete();
      answers_due_o <= 0;
    end else begin
      if (valid_i) begin
        got = '{action_e'(action_i), peer_ip_i, peer_mac_i};
        if (answers.size() == 0) begin
          report("unexpected result", '0, got);
        end else begin
          want = answers.pop_front();
          if (got !== want) begin
            report("result mismatch", want, got);
          end
        end
      end
      if (start_i && !busy_i) begin
        resolve_item(op_e'(operation_i), lookup_ip_i, arp_opcode_i, src_ip_i,
                     src_mac_i, tgt_ip_i);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_OWN_IP: begin
            own_ip = cfg_data_i[IpW-1:0];
          end
          REG_OWN_MAC: begin
            own_mac = cfg_data_i[MacW-1:0];
          end
          default: begin
          end
        endcase
      end
      answers_due_o <= answers.size();
    end
  end

endmodule

FILE: test/tb_top.sv
// Testbench top for the ARP cache and responder: stimulus, configuration and verdict.
`timescale 1ns / 1ps

module tb_top;
  import acr_pkg::*;

  localparam int unsigned Entries       = EntriesDef;
  localparam int          ItemsPerPhase = 375;
  localparam int          SettleCycles  = Entries + 8;
  localparam int unsigned CycleLimit    = 400000;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                operation;
  logic [IpW-1:0]      lookup_ip;
  logic [OpcW-1:0]     arp_opcode;
  logic [IpW-1:0]      src_ip;
  logic [MacW-1:0]     src_mac;
  logic [IpW-1:0]      tgt_ip;
  logic                valid_o;
  logic [ActW-1:0]     action_o;
  logic [IpW-1:0]      peer_ip_o;
  logic [MacW-1:0]     peer_mac_o;
  logic                cfg_valid;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  mismatch_count;
  int                  answers_due;
  int unsigned         cycle_count;

  logic [IpW-1:0] cur_own_ip;
  logic [IpW-1:0] stored_ips [$];
  logic [IpW-1:0] dropped_ip;

  arp_cache_and_responder #(
    .ENTRIES(Entries)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operation_i (operation),
    .lookup_ip_i (lookup_ip),
    .arp_opcode_i(arp_opcode),
    .src_ip_i    (src_ip),
    .src_mac_i   (src_mac),
    .tgt_ip_i    (tgt_ip),
    .valid_o     (valid_o),
    .action_o    (action_o),
    .peer_ip_o   (peer_ip_o),
    .peer_mac_o  (peer_mac_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  arp_checker #(
    .ENTRIES(Entries)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .operation_i     (operation),
    .lookup_ip_i     (lookup_ip),
    .arp_opcode_i    (arp_opcode),
    .src_ip_i        (src_ip),
    .src_mac_i       (src_mac),
    .tgt_ip_i        (tgt_ip),
    .valid_i         (valid_o),
    .action_i        (action_o),
    .peer_ip_i       (peer_ip_o),
    .peer_mac_i      (peer_mac_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .mismatch_count_o(mismatch_count),
    .answers_due_o   (answers_due)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [MacW-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[MacW-1:0];
  endfunction

  function automatic logic [OpcW-1:0] rand_opc();
    return OpcW'($urandom());
  endfunction

  task automatic send_item(input op_e op, input logic [IpW-1:0] lip,
                           input logic [OpcW-1:0] opc, input logic [IpW-1:0] sip,
                           input logic [MacW-1:0] smac, input logic [IpW-1:0] tip);
    operation  <= op;
    lookup_ip  <= lip;
    arp_opcode <= opc;
    src_ip     <= sip;
    src_mac    <= smac;
    tgt_ip     <= tip;
    start      <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (op == OP_PACKET && opc == ArpReply) begin
      if (stored_ips.size() < Entries) begin
        stored_ips.push_back(sip);
      end else begin
        dropped_ip = sip;
      end
    end
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (answers_due != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_identity(input logic [IpW-1:0] ip, input logic [MacW-1:0] mac);
    cfg_index <= REG_OWN_IP;
    cfg_data  <= CfgDataW'(ip);
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index <= REG_OWN_MAC;
    cfg_data  <= mac;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid  <= 1'b0;
    cur_own_ip = ip;
  endtask

  task automatic random_item();
    int              pick;
    logic [IpW-1:0]  lip;
    logic [IpW-1:0]  sip;
    logic [IpW-1:0]  tip;
    logic [MacW-1:0] smac;
    logic [OpcW-1:0] opc;
    pick = $urandom_range(0, 99);
    lip  = $urandom();
    sip  = $urandom();
    tip  = $urandom();
    smac = rand_mac();
    opc  = rand_opc();
    if (pick < 45) begin
      if ($urandom_range(0, 1) == 1) begin
        lip = stored_ips[$urandom_range(0, stored_ips.size() - 1)];
      end else if ($urandom_range(0, 9) == 0) begin
        lip = dropped_ip;
      end
      send_item(OP_LOOKUP, lip, opc, sip, smac, tip);
    end else if (pick < 75) begin
      if ($urandom_range(0, 9) < 6) begin
        tip = cur_own_ip;
      end
      send_item(OP_PACKET, lip, ArpRequest, sip, smac, tip);
    end else if (pick < 90) begin
      send_item(OP_PACKET, lip, ArpReply, sip, smac, tip);
    end else begin
      while (opc == ArpRequest || opc == ArpReply) opc = rand_opc();
      send_item(OP_PACKET, lip, opc, sip, smac, tip);
    end
  endtask

  initial begin : stimulus
    int              idle_pct;
    logic [IpW-1:0]  dup_ip;
    logic [MacW-1:0] r_mac;
    cycle_count = 0;
    cur_own_ip  = '0;
    dropped_ip  = '0;
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    operation  <= OP_LOOKUP;
    lookup_ip  <= '0;
    arp_opcode <= '0;
    src_ip     <= '0;
    src_mac    <= '0;
    tgt_ip     <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_OWN_IP;
    cfg_data   <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, reset identity
    dup_ip = 32'hC0A8_0001;
    r_mac  = rand_mac();
    send_item(OP_LOOKUP, '1, rand_opc(), $urandom(), rand_mac(), $urandom());
    send_item(OP_PACKET, $urandom(), ArpRequest, '1, '1, '0);
    send_item(OP_PACKET, $urandom(), ArpRequest, $urandom(), rand_mac(), 32'd1);
    send_item(OP_PACKET, $urandom(), 16'h0000, $urandom(), rand_mac(), '0);
    send_item(OP_PACKET, $urandom(), 16'hFFFF, $urandom(), rand_mac(), '0);
    send_item(OP_PACKET, $urandom(), ArpReply, dup_ip, r_mac, $urandom());
    send_item(OP_PACKET, $urandom(), ArpReply, dup_ip, ~r_mac, $urandom());
    send_item(OP_LOOKUP, dup_ip, rand_opc(), $urandom(), rand_mac(), $urandom());
    send_item(OP_PACKET, $urandom(), ArpReply, '0, '0, $urandom());
    send_item(OP_LOOKUP, '0, rand_opc(), $urandom(), rand_mac(), $urandom());
    send_item(OP_LOOKUP, 32'd1, rand_opc(), $urandom(), rand_mac(), $urandom());
    // fill the table, then overflow it
    while (stored_ips.size() < Entries) begin
      send_item(OP_PACKET, $urandom(), ArpReply, $urandom(), rand_mac(), $urandom());
    end
    send_item(OP_PACKET, $urandom(), ArpReply, 32'h0A00_00FE, rand_mac(), $urandom());
    send_item(OP_LOOKUP, dropped_ip, rand_opc(), $urandom(), rand_mac(), $urandom());
    send_item(OP_LOOKUP, stored_ips[Entries-1], rand_opc(), $urandom(), rand_mac(),
              $urandom());

    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        1: begin
          set_identity('0, '0);
          idle_pct = 63;
        end
        2: begin
          set_identity('1, '1);
          idle_pct = 16;
        end
        default: begin
          set_identity($urandom(), rand_mac());
          idle_pct = 0;
        end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        random_item();
        if ($urandom_range(0, 99) < idle_pct) begin
          hold_off($urandom_range(1, 12));
        end else if ($urandom_range(0, 63) == 0) begin
          drain();
        end
      end
    end
    drain();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/acr_pkg.sv
rtl/acr_ram.sv
rtl/arp_cache_and_responder.sv
rtl/acr_checker.sv
test/arp_checker.sv
test/tb_top.sv
